/* hdl/pfsa_pkg.sv */
package pfsa_pkg;

  localparam int ADDR_W          = 48;
  localparam int OP_W            = 3;
  localparam int STATUS_W        = 2;
  localparam int FREE_COUNT_W    = 13;
  localparam int STACK_DEPTH_DEF = 4096;
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
  // Page numbers of a 49-bit byte address: the region end may reach the top of space.
  localparam int PG_W            = ADDR_W + 1 - PAGE_SHIFT;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NULL  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_length;
    logic              region_usable;
    logic [ADDR_W-1:0] freed_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       page_address;
    logic [STATUS_W-1:0]     status;
    logic [FREE_COUNT_W-1:0] free_count;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_REGION,
    CMD_ALLOC,
    CMD_FREE,
    CMD_NULL_FREE,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [PG_W-1:0]   first_pg;
    logic [PG_W-1:0]   end_pg;
  } cmd_t;

endpackage

/* hdl/page_free_stack_allocator.sv */
// LIFO allocator of free page addresses. Each item carries one operation and
// yields exactly one result with the count of pages held afterwards. The front
// end decodes an item into a command in the cycle it is taken (page rounding
// of a region and clipping at the top of the 48-bit space happen here) and
// drops it into a two-entry queue; the back end owns the stack RAM and the
// count and executes commands in order. Clear, query, free and an ignored free
// finish in the idle state; allocate passes through a read state for the
// registered RAM read; add-region stays in a fill state while it pushes its
// pages, since the single RAM write port stores one page per cycle. A full
// stack drops the remaining pages and reports status full. The stack RAM is
// not initialized; only slots below the count are ever read. Results sit in
// an output register, so the queue keeps taking items while a result waits.
module page_free_stack_allocator #(
  parameter int STACK_DEPTH = pfsa_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pfsa_pkg::out_item_t out_data
);
  import pfsa_pkg::*;

  // front -> queue
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  // queue -> back
  logic q_valid;
  logic q_pop;
  cmd_t q_head_cmd;

  pfsa_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  pfsa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (q_head_cmd)
  );

  pfsa_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/pfsa_front.sv */
module pfsa_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  pfsa_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output pfsa_pkg::cmd_t    q_cmd
);
  import pfsa_pkg::*;

  logic [ADDR_W:0] start_sum;
  logic [ADDR_W:0] end_sum;
  logic [PG_W-1:0] first_pg;
  logic [PG_W-1:0] end_pg;

  // Purely combinational classification; the queue holds the result.
  assign start_sum = {1'b0, in_data.region_base} + (ADDR_W+1)'(PAGE_BYTES - 1);
  assign end_sum   = {1'b0, in_data.region_base} + {1'b0, in_data.region_length};
  assign first_pg  = start_sum[ADDR_W:PAGE_SHIFT];
  // end clipped to the top of the address space
  assign end_pg    = end_sum[ADDR_W] ? {1'b1, {(PG_W-1){1'b0}}} : end_sum[ADDR_W:PAGE_SHIFT];

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.addr     = in_data.freed_address;
    q_cmd.first_pg = first_pg;
    q_cmd.end_pg   = end_pg;
    unique case (in_data.operation)
      OP_CLEAR: q_cmd.kind = CMD_CLEAR;
      OP_ADD: begin
        if (in_data.region_usable && (first_pg < end_pg)) q_cmd.kind = CMD_REGION;
        else q_cmd.kind = CMD_QUERY;
      end
      OP_ALLOC: q_cmd.kind = CMD_ALLOC;
      OP_FREE: begin
        if (in_data.freed_address == '0) q_cmd.kind = CMD_NULL_FREE;
        else q_cmd.kind = CMD_FREE;
      end
      default: q_cmd.kind = CMD_QUERY;
    endcase
  end

endmodule

/* hdl/pfsa_fifo.sv */
module pfsa_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfsa_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pfsa_pkg::cmd_t head_cmd
);
  import pfsa_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] used_r, used_nxt;

  assign full     = (used_r == 2'd2);
  assign valid    = (used_r != 2'd0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    used_nxt   = used_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      used_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/pfsa_back.sv */
module pfsa_back #(
  parameter int STACK_DEPTH = pfsa_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pfsa_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pfsa_pkg::out_item_t out_data
);
  import pfsa_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_FILL, S_READ} state_t;

  logic [ADDR_W-1:0] stack_mem [STACK_DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PG_W-1:0] pg_r, pg_nxt;
  logic [PG_W-1:0] end_r, end_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic             out_free;
  logic             stack_full;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W-1:0] count_inc;
  logic             wr_en;
  logic             rd_en;
  logic [ADDR_W-1:0] wr_data;
  logic [ADDR_W-1:0] pg_addr;

  assign out_free   = !out_valid_r || !out_stall;
  assign stack_full = (count_r == CNT_W'(STACK_DEPTH));
  assign count_dec  = count_r - CNT_W'(1);
  assign count_inc  = count_r + CNT_W'(1);
  assign pg_addr    = ADDR_W'({pg_r, {PAGE_SHIFT{1'b0}}});

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pg_nxt        = pg_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_data       = q_cmd.addr;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop                     = 1'b1;
          out_data_nxt.page_address = '0;
          out_data_nxt.status       = ST_DONE;
          out_data_nxt.free_count   = FREE_COUNT_W'(count_r);
          unique case (q_cmd.kind)
            CMD_CLEAR: begin
              count_nxt               = '0;
              out_valid_nxt           = 1'b1;
              out_data_nxt.free_count = '0;
            end
            CMD_REGION: begin
              pg_nxt    = q_cmd.first_pg;
              end_nxt   = q_cmd.end_pg;
              state_nxt = S_FILL;
            end
            CMD_ALLOC: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                count_nxt = count_dec;
                state_nxt = S_READ;
              end
            end
            CMD_FREE: begin
              out_valid_nxt = 1'b1;
              if (stack_full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                wr_en                   = 1'b1;
                count_nxt               = count_inc;
                out_data_nxt.free_count = FREE_COUNT_W'(count_inc);
              end
            end
            CMD_NULL_FREE: begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_NULL;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        // output slot is empty here: IDLE only left with it free
        if ((pg_r != end_r) && !stack_full) begin
          wr_en     = 1'b1;
          wr_data   = pg_addr;
          count_nxt = count_inc;
          pg_nxt    = pg_r + PG_W'(1);
        end else begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.page_address = '0;
          out_data_nxt.status       = (pg_r == end_r) ? ST_DONE : ST_FULL;
          out_data_nxt.free_count   = FREE_COUNT_W'(count_r);
          state_nxt                 = S_IDLE;
        end
      end
      S_READ: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.page_address = rd_data_r;
        out_data_nxt.status       = ST_DONE;
        out_data_nxt.free_count   = FREE_COUNT_W'(count_r);
        state_nxt                 = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pg_r       <= pg_nxt;
    end_r      <= end_nxt;
    out_data_r <= out_data_nxt;
  end

  // stack storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[count_dec[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
